>>> hw/rtl/wbts_pkg.sv
package wbts_pkg;

  localparam int unsigned StoreTexels = 65536;
  localparam int unsigned MaxDimension = 4096;
  localparam int unsigned WeightFractionBits = 8;

  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgBase   = 2'd2,
    CfgFilter = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdWrite  = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              cmd;
    logic [15:0]       write_index;
    logic [31:0]       write_rgba;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
    logic [11:0]       offset_x;
    logic [11:0]       offset_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_item_t;

  // Clamp a dimension register to the range one to the maximum.
  function automatic logic [16:0] eff_dim(input logic [12:0] d, input logic [16:0] dmax);
    logic [16:0] r;
    r = {4'd0, d};
    if (d == 13'd0) begin
      r = 17'd1;
    end else if ({4'd0, d} > dmax) begin
      r = dmax;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/wrapped_bilinear_texture_sampler_core.sv
// Texture sampler with a repeat-wrapped RGBA8 texel store.
// Input channel in_valid/in_stall carries write items (cmd 0) that load
// one texel, and sample items (cmd 1) with Q15.16 u,v and texel offsets.
// Each sample item gives one result on out_valid/out_stall; write items
// give none. Configuration registers (width, height, base, filter) are
// written over cfg_valid/cfg_ready, by the user only while the block is
// idle; the block does not enforce this. While in_stall is low, one item
// is accepted per cycle. A sample item passes four front stages (scale with
// coarse offset reduction, fine offset reduction, wrap, row multiply), then
// the store read, weight product and blend stages. The store is held in
// four copies so all four neighbours are read in the same cycle.
// When the receiver stalls, results hold in the output register and the
// back end freezes; in_stall rises in that cycle once the last front stage
// holds a sample item that the frozen back end cannot take.
// Reset clears registers to width 1, height 1, base 0, nearest filter, and
// empties the pipeline; store contents are undefined until written.
module wrapped_bilinear_texture_sampler_core #(
  parameter int unsigned STORE_TEXELS = wbts_pkg::StoreTexels,
  parameter int unsigned MAX_DIMENSION = wbts_pkg::MaxDimension,
  parameter int unsigned WEIGHT_FRACTION_BITS = wbts_pkg::WeightFractionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbts_pkg::in_item_t  in_item_i,
  output logic                out_valid,
  input  logic                out_stall,
  output wbts_pkg::out_item_t out_item_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import wbts_pkg::*;

  localparam int unsigned AW = $clog2(STORE_TEXELS);
  localparam int unsigned FW = WEIGHT_FRACTION_BITS;

  logic [12:0] width_q, height_q;
  logic [15:0] base_q;
  logic        filter_q;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
      base_q   <= 16'd0;
      filter_q <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgWidth:  width_q  <= cfg_data_i[12:0];
        CfgHeight: height_q <= cfg_data_i[12:0];
        CfgBase:   base_q   <= cfg_data_i[15:0];
        CfgFilter: filter_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic          fq_valid, fq_ready, fq_cmd, fq_bilin;
  logic [AW-1:0] fq_addr [4];
  logic [31:0]   fq_data;
  logic [FW-1:0] fq_fx, fq_fy;

  wbts_front #(.STORE_TEXELS(STORE_TEXELS), .MAX_DIMENSION(MAX_DIMENSION),
               .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_item_i,
    .width_i(width_q), .height_i(height_q), .base_i(base_q), .filter_i(filter_q),
    .fq_valid_o(fq_valid), .fq_ready_i(fq_ready), .fq_cmd_o(fq_cmd),
    .fq_bilin_o(fq_bilin), .fq_addr_o(fq_addr), .fq_data_o(fq_data),
    .fq_fx_o(fq_fx), .fq_fy_o(fq_fy)
  );

  wbts_back #(.STORE_TEXELS(STORE_TEXELS),
              .WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .fq_valid_i(fq_valid), .fq_ready_o(fq_ready),
    .fq_cmd_i(fq_cmd), .fq_bilin_i(fq_bilin), .fq_addr_i(fq_addr),
    .fq_data_i(fq_data), .fq_fx_i(fq_fx), .fq_fy_i(fq_fy),
    .out_valid, .out_stall, .out_item_o
  );
endmodule

>>> hw/rtl/wbts_front.sv
// Front end: wraps coordinates, scales and reduces them to texel indices and addresses.
module wbts_front #(
  parameter int unsigned STORE_TEXELS = 65536,
  parameter int unsigned MAX_DIMENSION = 4096,
  parameter int unsigned WEIGHT_FRACTION_BITS = 8,
  localparam int unsigned AW = $clog2(STORE_TEXELS),
  localparam int unsigned FW = WEIGHT_FRACTION_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wbts_pkg::in_item_t   in_item_i,
  input  logic [12:0]          width_i,
  input  logic [12:0]          height_i,
  input  logic [15:0]          base_i,
  input  logic                 filter_i,
  output logic                 fq_valid_o,
  input  logic                 fq_ready_i,
  output logic                 fq_cmd_o,
  output logic                 fq_bilin_o,
  output logic [AW-1:0]        fq_addr_o [4],
  output logic [31:0]          fq_data_o,
  output logic [FW-1:0]        fq_fx_o,
  output logic [FW-1:0]        fq_fy_o
);
  import wbts_pkg::*;

  localparam logic [16:0] DMax = 17'(MAX_DIMENSION);

  // Six steps of restoring reduction of an offset by a dimension, using the
  // dimension shifted left by lo+5 down to lo.
  function automatic logic [11:0] reduce6(input logic [11:0] x, input logic [16:0] d,
                                          input int unsigned lo);
    logic [28:0] r;
    logic [28:0] m;
    r = 29'(x);
    for (int k = 5; k >= 0; k--) begin
      m = 29'(d) << (lo + k);
      if (r >= m) r = r - m;
    end
    return r[11:0];
  endfunction

  logic          s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic          s1_cmd_q, s2_cmd_q, s3_cmd_q, s4_cmd_q;
  logic          s1_bil_q, s2_bil_q, s3_bil_q, s4_bil_q;
  logic [16:0]   s1_w_q, s1_h_q, s2_w_q, s2_h_q, s3_w_q;
  logic [16:0]   s1_ui_q, s1_vi_q, s2_ui_q, s2_vi_q;
  logic [FW-1:0] s1_fx_q, s1_fy_q, s2_fx_q, s2_fy_q, s3_fx_q, s3_fy_q, fx_q, fy_q;
  logic [11:0]   s1_ox_q, s1_oy_q, s2_ox_q, s2_oy_q;
  logic [15:0]   s1_idx_q, s2_idx_q, s3_idx_q;
  logic [31:0]   s1_data_q, s2_data_q, s3_data_q, s4_data_q;
  logic [15:0]   s1_base_q, s2_base_q, s3_base_q;
  logic          adv;

  assign adv = !s4_v_q || fq_ready_i;
  assign in_stall = !adv;

  logic [16:0] w_e, h_e;
  logic [32:0] su, sv;
  assign w_e = eff_dim(width_i, DMax);
  assign h_e = eff_dim(height_i, DMax);
  assign su = {17'd0, in_item_i.u_coord[15:0]} * {16'd0, w_e};
  assign sv = {17'd0, in_item_i.v_coord[15:0]} * {16'd0, h_e};

  // Valid bits of the four front stages; the whole front moves together.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  // Stage one: scale the wrapped fractions and start reducing the offsets.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= in_item_i.cmd;
      s1_bil_q  <= filter_i;
      s1_w_q    <= w_e;
      s1_h_q    <= h_e;
      s1_ui_q   <= su[32:16];
      s1_vi_q   <= sv[32:16];
      s1_fx_q   <= su[15 -: FW];
      s1_fy_q   <= sv[15 -: FW];
      s1_ox_q   <= reduce6(in_item_i.offset_x, w_e, 6);
      s1_oy_q   <= reduce6(in_item_i.offset_y, h_e, 6);
      s1_idx_q  <= in_item_i.write_index;
      s1_data_q <= in_item_i.write_rgba;
      s1_base_q <= base_i;
    end
  end

  // Stage two: finish the offset reduction, leaving it below the dimension.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_bil_q  <= s1_bil_q;
      s2_w_q    <= s1_w_q;
      s2_h_q    <= s1_h_q;
      s2_ui_q   <= s1_ui_q;
      s2_vi_q   <= s1_vi_q;
      s2_fx_q   <= s1_fx_q;
      s2_fy_q   <= s1_fy_q;
      s2_ox_q   <= reduce6(s1_ox_q, s1_w_q, 0);
      s2_oy_q   <= reduce6(s1_oy_q, s1_h_q, 0);
      s2_idx_q  <= s1_idx_q;
      s2_data_q <= s1_data_q;
      s2_base_q <= s1_base_q;
    end
  end

  // Stage three: integer part plus reduced offset, wrapped by one subtraction,
  // and the next column and row.
  logic [17:0] cs, rs;
  logic [16:0] c0, r0, c1, r1;
  assign cs = 18'(s2_ui_q) + 18'(s2_ox_q);
  assign rs = 18'(s2_vi_q) + 18'(s2_oy_q);
  assign c0 = (cs >= 18'(s2_w_q)) ? 17'(cs - 18'(s2_w_q)) : 17'(cs);
  assign r0 = (rs >= 18'(s2_h_q)) ? 17'(rs - 18'(s2_h_q)) : 17'(rs);
  assign c1 = (c0 + 17'd1 == s2_w_q) ? 17'd0 : c0 + 17'd1;
  assign r1 = (r0 + 17'd1 == s2_h_q) ? 17'd0 : r0 + 17'd1;

  logic [16:0] s3_c0_q, s3_c1_q, s3_r0_q, s3_r1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_bil_q  <= s2_bil_q;
      s3_w_q    <= s2_w_q;
      s3_fx_q   <= s2_fx_q;
      s3_fy_q   <= s2_fy_q;
      s3_c0_q   <= c0;
      s3_c1_q   <= c1;
      s3_r0_q   <= r0;
      s3_r1_q   <= r1;
      s3_idx_q  <= s2_idx_q;
      s3_data_q <= s2_data_q;
      s3_base_q <= s2_base_q;
    end
  end

  // Stage four: row start addresses.
  logic [33:0] prod0, prod1;
  assign prod0 = s3_r0_q * s3_w_q;
  assign prod1 = s3_r1_q * s3_w_q;

  logic [AW-1:0] row0_q, row1_q, col0_q, col1_q;
  logic [AW-1:0] widx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_bil_q  <= s3_bil_q;
      s4_data_q <= s3_data_q;
      widx_q    <= AW'(s3_idx_q);
      row0_q    <= AW'(prod0) + AW'(s3_base_q);
      row1_q    <= AW'(prod1) + AW'(s3_base_q);
      col0_q    <= AW'(s3_c0_q);
      col1_q    <= AW'(s3_c1_q);
      fx_q      <= s3_fx_q;
      fy_q      <= s3_fy_q;
    end
  end

  assign fq_valid_o = s4_v_q;
  assign fq_cmd_o   = s4_cmd_q;
  assign fq_bilin_o = s4_bil_q;
  assign fq_data_o  = s4_data_q;
  assign fq_fx_o    = fx_q;
  assign fq_fy_o    = fy_q;
  assign fq_addr_o[0] = (s4_cmd_q == CmdWrite) ? widx_q : row0_q + col0_q;
  assign fq_addr_o[1] = row0_q + col1_q;
  assign fq_addr_o[2] = row1_q + col0_q;
  assign fq_addr_o[3] = row1_q + col1_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q && !fq_ready_i |=> s4_v_q) else $error("front item lost");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> s4_v_q) else $error("stall without held item");
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (17'(s2_ox_q) < s2_w_q)) else $error("offset not reduced");
  a_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (c0 < s2_w_q)) else $error("column not reduced");
endmodule

>>> hw/rtl/wbts_back.sv
// Back end: four store copies read in parallel, then blend and output register.
module wbts_back #(
  parameter int unsigned STORE_TEXELS = 65536,
  parameter int unsigned WEIGHT_FRACTION_BITS = 8,
  localparam int unsigned AW = $clog2(STORE_TEXELS),
  localparam int unsigned FW = WEIGHT_FRACTION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fq_valid_i,
  output logic                fq_ready_o,
  input  logic                fq_cmd_i,
  input  logic                fq_bilin_i,
  input  logic [AW-1:0]       fq_addr_i [4],
  input  logic [31:0]         fq_data_i,
  input  logic [FW-1:0]       fq_fx_i,
  input  logic [FW-1:0]       fq_fy_i,
  output logic                out_valid,
  input  logic                out_stall,
  output wbts_pkg::out_item_t out_item_o
);
  import wbts_pkg::*;

  localparam int unsigned SH = 2 * FW - 8;

  logic [31:0] mem0 [STORE_TEXELS];
  logic [31:0] mem1 [STORE_TEXELS];
  logic [31:0] mem2 [STORE_TEXELS];
  logic [31:0] mem3 [STORE_TEXELS];

  logic adv, take, wr;
  logic r_v_q, b_v_q, o_v_q;
  assign adv  = !o_v_q || !out_stall;
  assign take = fq_valid_i && (fq_cmd_i == CmdWrite || adv);
  assign fq_ready_o = (fq_cmd_i == CmdWrite) || adv;
  assign wr = fq_valid_i && fq_cmd_i == CmdWrite;

  // Memory read stage.
  logic [31:0] t_q [4];
  logic        bil_q, bil2_q;
  logic [FW-1:0] fx_q, fy_q;
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem0[fq_addr_i[0]] <= fq_data_i;
      mem1[fq_addr_i[0]] <= fq_data_i;
      mem2[fq_addr_i[0]] <= fq_data_i;
      mem3[fq_addr_i[0]] <= fq_data_i;
    end
    if (adv) begin
      t_q[0] <= mem0[fq_addr_i[0]];
      t_q[1] <= mem1[fq_addr_i[1]];
      t_q[2] <= mem2[fq_addr_i[2]];
      t_q[3] <= mem3[fq_addr_i[3]];
      bil_q  <= fq_bilin_i;
      fx_q   <= fq_fx_i;
      fy_q   <= fq_fy_i;
    end
  end

  // Weight products registered before the channel sum.
  logic [2*FW:0] w_q [4];
  logic [31:0]   t2_q [4];
  logic [FW:0] one;
  assign one = (FW+1)'(1) << FW;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q[0] <= (2*FW+1)'((one - fx_q) * (one - fy_q));
      w_q[1] <= (2*FW+1)'({1'b0, fx_q} * (one - fy_q));
      w_q[2] <= (2*FW+1)'((one - fx_q) * {1'b0, fy_q});
      w_q[3] <= (2*FW+1)'({1'b0, fx_q} * {1'b0, fy_q});
      t2_q   <= t_q;
      bil2_q <= bil_q;
    end
  end

  // Blend and output register.
  logic [15:0] ch_d [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [2*FW+10:0] acc;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + (2*FW+11)'(t2_q[k][8*c +: 8] * w_q[k]);
      end
      ch_d[c] = bil2_q ? 16'(acc >> SH) : {t2_q[0][8*c +: 8], 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q <= take && fq_cmd_i == CmdSample;
      b_v_q <= r_v_q;
      o_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_o <= '{red_out: ch_d[0], green_out: ch_d[1],
                      blue_out: ch_d[2], alpha_out: ch_d[3]};
    end
  end

  assign out_valid = o_v_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && b_v_q |=> o_v_q) else $error("blend stage lost item");
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_item_o.red_out <= 16'd65280) else $error("red out of range");
endmodule
